@@ src/fpsm_pkg.sv @@
// shared types and constants for the file to piece span mapper
// no dependencies

package fpsm_pkg;

  localparam int FILE_SIZE_W        = 48;
  localparam int FILE_SIZE_BITS_DEF = 48;
  localparam int PIECE_W            = 24;
  localparam int START_OFF_W        = 26;
  localparam int END_OFF_W          = 27;
  localparam int CFG_W              = 27;
  localparam int CFG_INDEX_W        = 1;

  localparam logic [CFG_W-1:0]   PS_RESET = 27'd262144;
  localparam logic [CFG_W-1:0]   PS_MAX   = 27'd67108864;
  localparam logic [PIECE_W-1:0] PC_RESET = 24'd0;

  localparam logic [CFG_INDEX_W-1:0] REG_PIECE_SIZE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIECE_COUNT = 1'b1;

  typedef struct packed {
    logic [FILE_SIZE_W-1:0] file_size;
    logic                   first_file;
  } file_item_t;

  typedef struct packed {
    logic [PIECE_W-1:0]     start_piece;
    logic [START_OFF_W-1:0] start_offset;
    logic [PIECE_W-1:0]     end_piece;
    logic [END_OFF_W-1:0]   end_offset;
    logic                   mapped;
  } span_item_t;

  typedef struct packed {
    logic accept;
    logic start_norm;
    logic start_span;
    logic apply_norm;
    logic apply_span;
    logic load_empty;
    logic finish;
  } fpsm_cmd_t;

  typedef struct packed {
    logic off_ge_ps;
    logic size_zero;
    logic div_done;
    logic out_free;
  } fpsm_sts_t;

endpackage

@@ src/fpsm_div.sv @@
// serial restoring divider, one quotient bit per cycle
// divisor up to 2^26, remainder below divisor; uses fpsm_pkg

module fpsm_div #(
  parameter int DW = 49
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DW-1:0]                  dividend,
  input  logic [fpsm_pkg::CFG_W-1:0]     divisor,
  output logic                           done,
  output logic [DW-1:0]                  quot,
  output logic [fpsm_pkg::START_OFF_W-1:0] rem
);
  import fpsm_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]          work;
  logic [START_OFF_W-1:0] part;
  logic [CW-1:0]          count;
  logic                   busy;
  logic [CFG_W-1:0]       trial;
  logic                   fits;
  logic [CFG_W-1:0]       diff;

  always_comb begin
    trial = {part, work[DW-1]};
    fits  = trial >= divisor;
    diff  = trial - divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      part <= '0;
    end else if (busy) begin
      if (fits) begin
        part <= diff[START_OFF_W-1:0];
        work <= {work[DW-2:0], 1'b1};
      end else begin
        part <= trial[START_OFF_W-1:0];
        work <= {work[DW-2:0], 1'b0};
      end
    end
  end

  assign quot = work;
  assign rem  = part;

endmodule

@@ src/fpsm_datapath.sv @@
// datapath: configuration, running position, span arithmetic, result register
// uses fpsm_pkg and fpsm_div

module fpsm_datapath #(
  parameter int FILE_SIZE_BITS = fpsm_pkg::FILE_SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [fpsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpsm_pkg::CFG_W-1:0]         cfg_data,
  input  fpsm_pkg::file_item_t               file_info,
  output fpsm_pkg::span_item_t               span_info,
  output logic                               span_valid,
  input  logic                               span_ready,
  input  fpsm_pkg::fpsm_cmd_t                cmd,
  output fpsm_pkg::fpsm_sts_t                sts
);
  import fpsm_pkg::*;

  localparam int SW    = (FILE_SIZE_BITS < FILE_SIZE_W) ? FILE_SIZE_BITS : FILE_SIZE_W;
  localparam int DW    = (SW + 1 > 27) ? SW + 1 : 27;
  localparam int CP_W  = 27;
  localparam int EP_W  = 28;

  logic [CFG_W-1:0]       piece_size;
  logic [PIECE_W-1:0]     piece_count;
  logic [CP_W-1:0]        cur_piece;
  logic [START_OFF_W-1:0] cur_offset;
  logic                   exhausted;
  logic [SW-1:0]          size;
  logic [EP_W-1:0]        end_piece;
  logic [END_OFF_W-1:0]   end_offset;

  logic [CFG_W-1:0]       ps_eff;
  logic [DW-1:0]          dividend;
  logic [DW-1:0]          quot;
  logic [START_OFF_W-1:0] rem;
  logic                   div_done;
  logic [PIECE_W:0]       span_cap;
  logic                   mapped;

  always_comb begin
    if (piece_size == '0) begin
      ps_eff = CFG_W'(1);
    end else if (piece_size > PS_MAX) begin
      ps_eff = PS_MAX;
    end else begin
      ps_eff = piece_size;
    end
  end

  always_comb begin
    if (cmd.start_norm) begin
      dividend = {{(DW-START_OFF_W){1'b0}}, cur_offset};
    end else begin
      dividend = {{(DW-START_OFF_W){1'b0}}, cur_offset} + {{(DW-SW){1'b0}}, size}
               - {{(DW-1){1'b0}}, 1'b1};
    end
  end

  fpsm_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_norm | cmd.start_span),
    .dividend (dividend),
    .divisor  (ps_eff),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // spans at or past 2^24 pieces can never be mapped
  always_comb begin
    if (|quot[DW-1:PIECE_W]) begin
      span_cap = {1'b1, {PIECE_W{1'b0}}};
    end else begin
      span_cap = {1'b0, quot[PIECE_W-1:0]};
    end
  end

  assign mapped = !exhausted && (end_piece < {{(EP_W-PIECE_W){1'b0}}, piece_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_size  <= PS_RESET;
      piece_count <= PC_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIECE_SIZE:  piece_size  <= cfg_data;
        REG_PIECE_COUNT: piece_count <= cfg_data[PIECE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_piece  <= '0;
      cur_offset <= '0;
      exhausted  <= 1'b0;
    end else if (cmd.accept) begin
      if (file_info.first_file) begin
        cur_piece  <= '0;
        cur_offset <= '0;
        exhausted  <= 1'b0;
      end
    end else if (cmd.apply_norm) begin
      cur_piece  <= cur_piece + quot[CP_W-1:0];
      cur_offset <= rem;
    end else if (cmd.finish) begin
      if (!mapped) begin
        exhausted <= 1'b1;
      end else if (end_offset >= ps_eff) begin
        cur_piece  <= end_piece[CP_W-1:0] + CP_W'(1);
        cur_offset <= '0;
      end else begin
        cur_piece  <= end_piece[CP_W-1:0];
        cur_offset <= end_offset[START_OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size <= file_info.file_size[SW-1:0];
    end
    if (cmd.apply_span) begin
      end_piece  <= {1'b0, cur_piece} + {{(EP_W-PIECE_W-1){1'b0}}, span_cap};
      end_offset <= {1'b0, rem} + END_OFF_W'(1);
    end else if (cmd.load_empty) begin
      end_piece  <= {1'b0, cur_piece};
      end_offset <= {1'b0, cur_offset};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (cmd.finish) begin
      span_valid <= 1'b1;
    end else if (span_ready) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mapped) begin
        span_info.start_piece  <= cur_piece[PIECE_W-1:0];
        span_info.start_offset <= cur_offset;
        span_info.end_piece    <= end_piece[PIECE_W-1:0];
        span_info.end_offset   <= end_offset;
        span_info.mapped       <= 1'b1;
      end else begin
        span_info <= '0;
      end
    end
  end

  always_comb begin
    sts.off_ge_ps = {1'b0, cur_offset} >= ps_eff;
    sts.size_zero = size == '0;
    sts.div_done  = div_done;
    sts.out_free  = !span_valid || span_ready;
  end

endmodule

@@ src/fpsm_ctrl.sv @@
// controller: sequences normalize, span divide or empty load, and result write per file
// uses fpsm_pkg

module fpsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                file_valid,
  output logic                file_ready,
  input  fpsm_pkg::fpsm_sts_t sts,
  output fpsm_pkg::fpsm_cmd_t cmd
);
  import fpsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_NORM = 5'b00100,
    S_SPAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    file_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        file_ready = 1'b1;
        if (file_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.off_ge_ps) begin
          cmd.start_norm = 1'b1;
          state_next     = S_NORM;
        end else if (sts.size_zero) begin
          cmd.load_empty = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.start_span = 1'b1;
          state_next     = S_SPAN;
        end
      end
      S_NORM: begin
        if (sts.div_done) begin
          cmd.apply_norm = 1'b1;
          state_next     = S_PREP;
        end
      end
      S_SPAN: begin
        if (sts.div_done) begin
          cmd.apply_span = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/file_to_piece_span_mapper.sv @@
// top level of the file to piece span mapper
// depends on fpsm_pkg, fpsm_ctrl, fpsm_datapath, fpsm_div
//
// channel   | direction | handshake               | payload
// file      | in        | file_valid / file_ready | file_info (file_size, first_file)
// span      | out       | span_valid / span_ready | span_info (start/end piece, offsets, mapped)
// cfg       | in        | cfg_write               | cfg_index, cfg_data
//
// one file at a time: accept, a prep state, a serial divide for the span
// (DW = max(size bits + 1, 27)), then a write of the result register; an empty
// file skips the divide, and a normalize divide comes first when the offset must be
// carried into pieces after a piece size change. one serial divider serves both.
// a finished result waits in the output register while the next file is taken.
// synchronous reset clears position, exhausted flag and span_valid, and resets configuration.

module file_to_piece_span_mapper #(
  parameter int FILE_SIZE_BITS = fpsm_pkg::FILE_SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fpsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpsm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             file_valid,
  output logic                             file_ready,
  input  fpsm_pkg::file_item_t             file_info,
  output logic                             span_valid,
  input  logic                             span_ready,
  output fpsm_pkg::span_item_t             span_info
);
  import fpsm_pkg::*;

  fpsm_cmd_t cmd;
  fpsm_sts_t sts;

  fpsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .file_valid (file_valid),
    .file_ready (file_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fpsm_datapath #(.FILE_SIZE_BITS(FILE_SIZE_BITS)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .file_info  (file_info),
    .span_info  (span_info),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result written while output register is occupied");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> !file_ready)
    else $error("divider finished with no file in progress");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    cmd.apply_norm |=> !sts.off_ge_ps)
    else $error("offset not below piece size after normalize");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (span_valid && !span_info.mapped) |->
      (span_info.start_piece == '0 && span_info.start_offset == '0 &&
       span_info.end_piece == '0 && span_info.end_offset == '0))
    else $error("unmapped transfer carries nonzero fields");

endmodule
